// File: rtl/core/rectangle_group_extractor_macros.svh
// Assertion macros shared by the rectangle group extractor RTL.
`ifndef RECTANGLE_GROUP_EXTRACTOR_MACROS_SVH
`define RECTANGLE_GROUP_EXTRACTOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, masked during reset.
`define RGE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, masked during reset.
`define RGE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGE_ASSERT_IMP(lbl, ante, cons, msg)
`define RGE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/rge_pkg.sv
// Shared constants and types of the rectangle group extractor.
package rge_pkg;

  localparam int MAX_COLS   = 512;
  localparam int MAX_ROWS   = 512;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 10;
  localparam int SIZE_RESET = 512;
  localparam int FIELD_W    = 9;
  localparam int GRP_W      = 16;
  localparam int EPOCH_W    = 8;
  localparam int MAX_RES    = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CNTX_W     = CNT_W + 1;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register index, taken from paddr bit 2
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } clr_state_t;

  // Open-rectangle entry, written when a run ends
  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   top;
    logic [COL_W-1:0]   right;
  } ent_a_t;

  // Consume mark, written when an entry is used up
  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [ROW_W-1:0]   row;
  } ent_b_t;

  localparam int ENT_A_W = $bits(ent_a_t);
  localparam int ENT_B_W = $bits(ent_b_t);

  typedef struct packed {
    logic [FIELD_W-1:0] top_row;
    logic [FIELD_W-1:0] left_col;
    logic [FIELD_W-1:0] bottom_row;
    logic [FIELD_W-1:0] right_col;
    logic [GRP_W-1:0]   group_index;
    logic               last;
  } res_t;

  // Pixel context handed from the accept stage to the store stage
  typedef struct packed {
    logic               pix;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               start;
    logic               ended;
    logic [COL_W-1:0]   end_col;
    logic [COL_W-1:0]   slot;
    logic               lastrow;
    logic               imgend;
    logic [EPOCH_W-1:0] epoch;
  } s1_t;

endpackage

// File: rtl/core/rge_if.sv
// Valid/ready channel interfaces for pixels in and rectangles out.
interface rge_pix_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rge_res_if;
  logic                        valid;
  logic                        ready;
  logic [rge_pkg::FIELD_W-1:0] top_row;
  logic [rge_pkg::FIELD_W-1:0] left_col;
  logic [rge_pkg::FIELD_W-1:0] bottom_row;
  logic [rge_pkg::FIELD_W-1:0] right_col;
  logic [rge_pkg::GRP_W-1:0]   group_index;
  logic                        last;

  modport source (output valid, output top_row, output left_col, output bottom_row,
                  output right_col, output group_index, output last, input ready);
  modport sink   (input valid, input top_row, input left_col, input bottom_row,
                  input right_col, input group_index, input last, output ready);
endinterface

// File: rtl/core/rge_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rge_res_fifo.sv
// Result queue: takes up to two rectangles a cycle, gives one.
module rge_res_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                push_cnt,
  input  rge_pkg::res_t             push0,
  input  rge_pkg::res_t             push1,
  input  logic                      pop,
  output rge_pkg::res_t             head,
  output logic                      nempty,
  output logic [rge_pkg::CNT_W-1:0] count
);

  rge_pkg::res_t                   store_r [rge_pkg::FIFO_DEPTH];
  logic [rge_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rge_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rge_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            pop_ok;

  assign pop_ok = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + rge_pkg::FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + rge_pkg::FIFO_AW'(pop_ok);
    cnt_nxt    = cnt_r + rge_pkg::CNT_W'(push_cnt) - rge_pkg::CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      store_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      store_r[wr_ptr_r + rge_pkg::FIFO_AW'(1)] <= push1;
    end
  end

  assign head   = store_r[rd_ptr_r];
  assign nempty = (cnt_r != '0);
  assign count  = cnt_r;

endmodule

// File: rtl/core/rectangle_group_extractor.sv
// Rectangle group extractor: one pixel a cycle in while ready, rectangle corners out in order
// of completion. Ready needs room in the result queue and is low during a clearing sweep.
// Throughput: one pixel per cycle when ready, bounded by each column store's single write port.
// After reset, and after every 256th image, a sweep clears both stores; no pixel is taken.
// Reset: synchronous, active low; sizes return to 512x512, counters and queue to empty.
`include "rectangle_group_extractor_macros.svh"

module rectangle_group_extractor (
  input  logic                        clk,
  input  logic                        rst_n,
  rge_pix_if.sink                     in_pix,
  rge_res_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rge_pkg::PADDR_W-1:0] paddr,
  input  logic [rge_pkg::PDATA_W-1:0] pwdata,
  output logic [rge_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rge_pkg::SIZE_W-1:0] img_w_r, img_h_r;
  logic [rge_pkg::SIZE_W-1:0] w_eff, h_eff;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= rge_pkg::SIZE_W'(rge_pkg::SIZE_RESET);
      img_h_r <= rge_pkg::SIZE_W'(rge_pkg::SIZE_RESET);
    end else if (cfg_we) begin
      case (paddr[2])
        rge_pkg::REG_WIDTH:  img_w_r <= pwdata[rge_pkg::SIZE_W-1:0];
        rge_pkg::REG_HEIGHT: img_h_r <= pwdata[rge_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rge_pkg::REG_WIDTH:  prdata = rge_pkg::PDATA_W'(img_w_r);
      rge_pkg::REG_HEIGHT: prdata = rge_pkg::PDATA_W'(img_h_r);
      default:             prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the store size is clamped
  always_comb begin
    if (img_w_r == '0) begin
      w_eff = rge_pkg::SIZE_W'(1);
    end else if (img_w_r > rge_pkg::SIZE_W'(rge_pkg::MAX_COLS)) begin
      w_eff = rge_pkg::SIZE_W'(rge_pkg::MAX_COLS);
    end else begin
      w_eff = img_w_r;
    end
    if (img_h_r == '0) begin
      h_eff = rge_pkg::SIZE_W'(1);
    end else if (img_h_r > rge_pkg::SIZE_W'(rge_pkg::MAX_ROWS)) begin
      h_eff = rge_pkg::SIZE_W'(rge_pkg::MAX_ROWS);
    end else begin
      h_eff = img_h_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: raster position and run tracking, store read issue
  // ---------------------------------------------------------------------------
  logic [rge_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [rge_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic                        prev_r, prev_nxt;
  logic [rge_pkg::COL_W-1:0]   run_start_r, run_start_nxt;
  logic [rge_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic                        accept;
  logic                        lastcol, lastrow, imgend, start0;
  rge_pkg::s1_t                s1_nxt, s1_r;
  logic                        s1_valid_r;

  rge_pkg::clr_state_t         state_r, state_nxt;
  logic [rge_pkg::COL_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                        clr_we, run_en, clr_done, wrap_start;

  logic [rge_pkg::CNT_W-1:0]   fifo_cnt;
  logic [rge_pkg::CNTX_W-1:0]  room_need;

  assign accept  = in_pix.valid && in_pix.ready;
  assign lastcol = (rge_pkg::SIZE_W'(col_r) + rge_pkg::SIZE_W'(1)) >= w_eff;
  assign lastrow = (rge_pkg::SIZE_W'(row_r) + rge_pkg::SIZE_W'(1)) >= h_eff;
  assign imgend  = lastcol && lastrow;
  assign start0  = in_pix.pixel && !prev_r;

  // Worst case: the pixel in stage 1 and the one taken now each add two results
  assign room_need = rge_pkg::CNTX_W'(fifo_cnt)
                   + (s1_valid_r ? rge_pkg::CNTX_W'(2 * rge_pkg::MAX_RES)
                                 : rge_pkg::CNTX_W'(rge_pkg::MAX_RES));
  assign in_pix.ready = run_en && (room_need <= rge_pkg::CNTX_W'(rge_pkg::FIFO_DEPTH));

  always_comb begin
    s1_nxt.pix     = in_pix.pixel;
    s1_nxt.col     = col_r;
    s1_nxt.row     = row_r;
    s1_nxt.start   = start0;
    // a run closes on a falling edge or at the row's last column
    s1_nxt.ended   = (!in_pix.pixel && prev_r) || (in_pix.pixel && lastcol);
    s1_nxt.end_col = (in_pix.pixel && lastcol) ? col_r : col_r - rge_pkg::COL_W'(1);
    s1_nxt.slot    = start0 ? col_r : run_start_r;
    s1_nxt.lastrow = lastrow;
    s1_nxt.imgend  = imgend;
    s1_nxt.epoch   = epoch_r;
  end

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    prev_nxt      = prev_r;
    run_start_nxt = run_start_r;
    epoch_nxt     = epoch_r;
    if (accept) begin
      prev_nxt = lastcol ? 1'b0 : in_pix.pixel;
      if (start0) begin
        run_start_nxt = col_r;
      end
      if (lastcol) begin
        col_nxt = '0;
        row_nxt = lastrow ? '0 : row_r + rge_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + rge_pkg::COL_W'(1);
      end
      // a fresh epoch per image makes every older entry stale at once
      if (imgend) begin
        epoch_nxt = epoch_r + rge_pkg::EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      prev_r      <= 1'b0;
      run_start_r <= '0;
      epoch_r     <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      prev_r      <= prev_nxt;
      run_start_r <= run_start_nxt;
      epoch_r     <= epoch_nxt;
      s1_valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep: after reset and once the epoch wraps
  // ---------------------------------------------------------------------------
  assign clr_done   = clr_we && (clr_addr_r == rge_pkg::COL_W'(rge_pkg::MAX_COLS - 1));
  assign wrap_start = accept && imgend && (epoch_r == '1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rge_pkg::ST_CLEAR: if (clr_done) begin
        state_nxt = rge_pkg::ST_RUN;
      end
      rge_pkg::ST_RUN: if (wrap_start) begin
        state_nxt = rge_pkg::ST_CLEAR;
      end
      default: state_nxt = rge_pkg::ST_CLEAR;
    endcase
  end

  // Sweep waits while the last pixel still owns the write ports
  always_comb begin
    clr_we = 1'b0;
    run_en = 1'b0;
    case (state_r)
      rge_pkg::ST_CLEAR: clr_we = !s1_valid_r;
      rge_pkg::ST_RUN:   run_en = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (clr_we) begin
      clr_addr_nxt = clr_done ? '0 : clr_addr_r + rge_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rge_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Column stores.
  // A: open rectangle {top, right} stamped with the row it was written in.
  // B: consume mark stamped with the row it was used up in.
  // An A entry is live if its epoch is current and no later consume mark exists;
  // within a row a write to a slot always follows that slot's consume.
  // ---------------------------------------------------------------------------
  logic [rge_pkg::ENT_A_W-1:0] a_q, a_wdata;
  logic [rge_pkg::ENT_B_W-1:0] b_q, b_wdata;
  logic [rge_pkg::COL_W-1:0]   a_waddr, b_waddr;
  logic                        a_we, b_we;
  logic                        a_we_s1, consume;
  rge_pkg::ent_a_t             a_wr_ent, a_fwd_data_r, ea;
  rge_pkg::ent_b_t             b_wr_ent, b_fwd_data_r, eb;
  logic                        a_fwd_r, b_fwd_r;

  assign a_we    = a_we_s1 || clr_we;
  assign a_waddr = clr_we ? clr_addr_r : s1_r.slot;
  assign a_wdata = clr_we ? '0 : a_wr_ent;
  assign b_we    = consume || clr_we;
  assign b_waddr = clr_we ? clr_addr_r : s1_r.col;
  assign b_wdata = clr_we ? '0 : b_wr_ent;

  rge_ram #(
    .WIDTH (rge_pkg::ENT_A_W),
    .DEPTH (rge_pkg::MAX_COLS)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (col_r),
    .rdata (a_q)
  );

  rge_ram #(
    .WIDTH (rge_pkg::ENT_B_W),
    .DEPTH (rge_pkg::MAX_COLS)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (col_r),
    .rdata (b_q)
  );

  // Stage 1 writes land in the same cycle the next pixel reads: bypass them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_fwd_r <= 1'b0;
      b_fwd_r <= 1'b0;
    end else begin
      a_fwd_r <= a_we_s1 && (s1_r.slot == col_r);
      b_fwd_r <= consume && (s1_r.col == col_r);
    end
  end

  always_ff @(posedge clk) begin
    a_fwd_data_r <= a_wr_ent;
    b_fwd_data_r <= b_wr_ent;
  end

  assign ea = a_fwd_r ? a_fwd_data_r : rge_pkg::ent_a_t'(a_q);
  assign eb = b_fwd_r ? b_fwd_data_r : rge_pkg::ent_b_t'(b_q);

  // ---------------------------------------------------------------------------
  // Stage 1: resolve the entry, update runs, emit rectangles
  // ---------------------------------------------------------------------------
  logic                        a_live, b_live, evalid;
  logic                        e1, e2;
  logic [rge_pkg::ROW_W-1:0]   top_in, top_end;
  logic [rge_pkg::ROW_W-1:0]   run_top_r, run_top_nxt;
  logic [rge_pkg::GRP_W-1:0]   grp_r, grp_nxt;
  logic [1:0]                  push_n;
  rge_pkg::res_t               res_above, res_run, push0, push1, head;
  logic                        fifo_nempty, pop;

  assign a_live = ea.valid && (ea.epoch == s1_r.epoch);
  assign b_live = eb.valid && (eb.epoch == s1_r.epoch);
  assign evalid = a_live && !(b_live && (eb.row > ea.row));

  // rectangle closed in the row above: a live entry meets forest
  assign e1      = s1_valid_r && evalid && !s1_r.pix;
  // entry used up: closed, or run into from inside an open run
  assign consume = s1_valid_r && evalid && (!s1_r.pix || !s1_r.start);
  assign top_in  = evalid ? ea.top : s1_r.row;
  assign top_end = s1_r.start ? top_in : run_top_r;
  assign a_we_s1 = s1_valid_r && s1_r.ended;
  // in the last row the rectangle closes at once
  assign e2      = s1_valid_r && s1_r.ended && s1_r.lastrow;

  always_comb begin
    a_wr_ent.valid = !s1_r.lastrow;
    a_wr_ent.epoch = s1_r.epoch;
    a_wr_ent.row   = s1_r.row;
    a_wr_ent.top   = top_end;
    a_wr_ent.right = s1_r.end_col;
    b_wr_ent.valid = 1'b1;
    b_wr_ent.epoch = s1_r.epoch;
    b_wr_ent.row   = s1_r.row;
  end

  always_comb begin
    res_above.top_row     = rge_pkg::FIELD_W'(ea.top);
    res_above.left_col    = rge_pkg::FIELD_W'(s1_r.col);
    res_above.bottom_row  = rge_pkg::FIELD_W'(s1_r.row - rge_pkg::ROW_W'(1));
    res_above.right_col   = rge_pkg::FIELD_W'(ea.right);
    res_above.group_index = grp_r;
    res_above.last        = !e2;

    res_run.top_row       = rge_pkg::FIELD_W'(top_end);
    res_run.left_col      = rge_pkg::FIELD_W'(s1_r.slot);
    res_run.bottom_row    = rge_pkg::FIELD_W'(s1_r.row);
    res_run.right_col     = rge_pkg::FIELD_W'(s1_r.end_col);
    res_run.group_index   = e1 ? grp_r + rge_pkg::GRP_W'(1) : grp_r;
    res_run.last          = 1'b1;

    // closed-above result always goes first
    push0  = e1 ? res_above : res_run;
    push1  = res_run;
    push_n = 2'(e1) + 2'(e2);
  end

  always_comb begin
    run_top_nxt = run_top_r;
    grp_nxt     = grp_r;
    if (s1_valid_r) begin
      if (s1_r.start) begin
        run_top_nxt = top_in;
      end
      grp_nxt = s1_r.imgend ? '0 : grp_r + rge_pkg::GRP_W'(push_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_top_r <= '0;
      grp_r     <= '0;
    end else begin
      run_top_r <= run_top_nxt;
      grp_r     <= grp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  assign pop = out_res.valid && out_res.ready;

  rge_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_n),
    .push0    (push0),
    .push1    (push1),
    .pop      (pop),
    .head     (head),
    .nempty   (fifo_nempty),
    .count    (fifo_cnt)
  );

  assign out_res.valid       = fifo_nempty;
  assign out_res.top_row     = head.top_row;
  assign out_res.left_col    = head.left_col;
  assign out_res.bottom_row  = head.bottom_row;
  assign out_res.right_col   = head.right_col;
  assign out_res.group_index = head.group_index;
  assign out_res.last        = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RGE_ASSERT_IMP(a_queue_room, s1_valid_r, (rge_pkg::CNTX_W'(fifo_cnt) + rge_pkg::CNTX_W'(push_n)) <= rge_pkg::CNTX_W'(rge_pkg::FIFO_DEPTH), "result queue overflow")
  `RGE_ASSERT_IMP(a_slot_order, s1_valid_r && s1_r.ended, s1_r.slot <= s1_r.col, "run start beyond current column")
  `RGE_ASSERT_IMP(a_no_top_close, e1, s1_r.row != '0, "rectangle closed above the first row")
  `RGE_ASSERT_NXT(a_pair_order, out_res.valid && out_res.ready && !out_res.last, out_res.valid && out_res.last, "second result of a pixel missing")

endmodule
